### hdl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

    localparam int BLOCK_BYTES = 1024;
    localparam int BLK_SHIFT   = 10;
    localparam int SIZE_W      = 32;
    localparam int ADDR_W      = 32;
    localparam int BYTES_W     = 26;
    localparam int BLKS_W      = SIZE_W - BLK_SHIFT + 1;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 64;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISALIGN = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_SKIP,
        S_SKIP_EV,
        S_FIT,
        S_CHK,
        S_CHK_EV,
        S_WRITE,
        S_QRD,
        S_DONE
    } t_state;

endpackage

### hdl/ffba_table.sv
// Run-length table RAM: one write port, one registered read port.
module ffba_table
    import ffba_pkg::*;
#(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/first_fit_block_allocator_core.sv
// Top level of the first-fit fixed-block allocator.
// Manages POOL_BLOCKS blocks of 1 KiB starting at pool_base through a run-length table in a
// single-port-read RAM, walked by one adder under a small sequencer. After reset the table is
// cleared one entry a cycle, and no request is taken until that pass is done. A request is
// taken only while the sequencer is idle. Allocate reads one table entry for each taken run
// head jumped over, each entry checked inside a candidate run and the free entry that starts
// a candidate, each step bounded by the registered RAM read, then grants or reports out of
// memory; free writes and query reads the entry at the given address. The result sits in an
// output register, so the next request is taken while it waits.
module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int POOL_BLOCKS = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [ADDR_W-1:0]    i_cfg_wr_data,     // pool_base
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,    // [31:0] byte_size, [63:32] address
    input  logic [REQ_W-1:0]     i_s_axis_tuser,    // [1:0] req_type
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,    // [31:0] alloc_address, [57:32] alloc_bytes
    output logic [STAT_W-1:0]    o_m_axis_tuser     // [1:0] status
);

    localparam int AW  = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int EW  = $clog2(POOL_BLOCKS + 1);
    localparam int IW  = EW + 1;
    localparam int SW  = ((IW > BLKS_W) ? IW : BLKS_W) + 1;
    localparam logic [ADDR_W:0] SPAN = (ADDR_W + 1)'(POOL_BLOCKS) << BLK_SHIFT;
    localparam logic [IW-1:0]   NBLK_I = IW'(POOL_BLOCKS);
    localparam logic [SW-1:0]   NBLK_S = SW'(POOL_BLOCKS);
    localparam logic [AW-1:0]   LAST_ENTRY = AW'(POOL_BLOCKS - 1);

    t_state r_state, n_state;
    logic [ADDR_W-1:0]  r_base;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [BLKS_W-1:0]  r_blocks, n_blocks;
    logic [ADDR_W-1:0]  r_addr_in, n_addr_in;
    logic [IW-1:0]      r_i, n_i;
    logic [BLKS_W-1:0]  r_j, n_j;
    logic [AW-1:0]      r_clr, n_clr;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic [BYTES_W-1:0] r_res_bytes, n_res_bytes;
    logic               r_ovalid, n_ovalid;
    logic [STAT_W-1:0]  r_ostat, n_ostat;
    logic [ADDR_W-1:0]  r_oaddr, n_oaddr;
    logic [BYTES_W-1:0] r_obytes, n_obytes;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [EW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [EW-1:0]     mem_rdata;

    logic [SW-1:0]     add_b;
    logic [SW-1:0]     sum;
    logic [ADDR_W:0]   off;
    logic              in_pool;
    logic [AW-1:0]     off_blk;
    logic [SIZE_W:0]   size_up;
    logic [BLKS_W-1:0] size_blks;

    ffba_table #(
        .DEPTH  (POOL_BLOCKS),
        .ADDR_W (AW),
        .DATA_W (EW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // shared adder for the table walk
    always_comb begin
        unique case (r_state)
            S_SKIP_EV:         add_b = SW'(mem_rdata);
            S_FIT:             add_b = SW'(r_blocks);
            S_CHK, S_CHK_EV:   add_b = SW'(r_j);
            default:           add_b = '0;
        endcase
    end
    assign sum = SW'(r_i) + add_b;

    assign off     = {1'b0, r_addr_in} - {1'b0, r_base};
    assign in_pool = !off[ADDR_W] && (off < SPAN);
    assign off_blk = off[AW+BLK_SHIFT-1:BLK_SHIFT];

    assign size_up   = {1'b0, i_s_axis_tdata[SIZE_W-1:0]} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
    assign size_blks = size_up[SIZE_W:BLK_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_blocks    <= n_blocks;
        r_addr_in   <= n_addr_in;
        r_i         <= n_i;
        r_j         <= n_j;
        r_status    <= n_status;
        r_res_addr  <= n_res_addr;
        r_res_bytes <= n_res_bytes;
        r_ostat     <= n_ostat;
        r_oaddr     <= n_oaddr;
        r_obytes    <= n_obytes;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_blocks    = r_blocks;
        n_addr_in   = r_addr_in;
        n_i         = r_i;
        n_j         = r_j;
        n_clr       = r_clr;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        n_res_bytes = r_res_bytes;
        n_ovalid    = r_ovalid && !i_m_axis_tready;
        n_ostat     = r_ostat;
        n_oaddr     = r_oaddr;
        n_obytes    = r_obytes;
        mem_we      = 1'b0;
        mem_waddr   = r_i[AW-1:0];
        mem_wdata   = '0;
        mem_raddr   = sum[AW-1:0];
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ENTRY) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_req       = i_s_axis_tuser;
                    n_addr_in   = i_s_axis_tdata[S_TDATA_W-1:SIZE_W];
                    n_blocks    = (size_blks == '0) ? BLKS_W'(1) : size_blks;
                    n_i         = '0;
                    n_status    = ST_OK;
                    n_res_addr  = '0;
                    n_res_bytes = '0;
                    unique case (i_s_axis_tuser)
                        REQ_ALLOC:            n_state = S_SKIP;
                        REQ_FREE, REQ_QUERY:  n_state = S_ADDR;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_ADDR: begin
                mem_raddr = off_blk;
                if (!in_pool) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else if (r_req == REQ_FREE) begin
                    mem_we    = 1'b1;
                    mem_waddr = off_blk;
                    if (off[BLK_SHIFT-1:0] != '0) begin
                        n_status = ST_MISALIGN;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                n_res_bytes = BYTES_W'({mem_rdata, {BLK_SHIFT{1'b0}}});
                n_state     = S_DONE;
            end
            S_SKIP: begin
                if (r_i >= NBLK_I) begin
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SKIP_EV;
                end
            end
            S_SKIP_EV: begin
                if (mem_rdata != '0) begin
                    n_i     = sum[IW-1:0];
                    n_state = S_SKIP;
                end else begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (sum > NBLK_S) begin
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_j     = BLKS_W'(1);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_j >= r_blocks) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_CHK_EV;
                end
            end
            S_CHK_EV: begin
                if (mem_rdata != '0) begin
                    n_i     = sum[IW-1:0];
                    n_state = S_SKIP;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_CHK;
                end
            end
            S_WRITE: begin
                mem_we     = 1'b1;
                mem_waddr  = r_i[AW-1:0];
                mem_wdata  = EW'(r_blocks);
                n_res_addr = r_base + (ADDR_W'(r_i) << BLK_SHIFT);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_status;
                    n_oaddr  = r_res_addr;
                    n_obytes = r_res_bytes;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tdata  = {{(M_TDATA_W - ADDR_W - BYTES_W){1'b0}}, r_obytes, r_oaddr};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while sequencer busy");

    a_run_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ((SW'(r_i) + SW'(r_blocks)) <= NBLK_S))
        else $error("granted run passes pool end");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !i_m_axis_tready) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr == LAST_ENTRY) |=> (r_state == S_IDLE))
        else $error("clearing pass did not finish");

endmodule
